// File: rtl/core/dhbd_pkg.sv
// Shared types and constants of the detection head box decoder.
// Holds the divider command/response structs and the register index codes.
// No dependencies.
package dhbd_pkg;

   localparam int unsigned NET_INPUT_SIZE = 640;
   localparam int unsigned MAX_CLASSES    = 80;

   localparam int unsigned SCORE_W = 16;
   localparam int unsigned CLASS_W = 8;
   localparam int unsigned DIM_W   = 13;

   // Operand and result widths of the multiply/divide path.
   localparam int unsigned OPND_W = 13;
   localparam int unsigned PROD_W = 2 * OPND_W;
   localparam int unsigned DEN_W  = DIM_W + 1;
   localparam int unsigned DVSR_W = DEN_W + 1;
   localparam int unsigned DIVD_W = PROD_W + 2;
   localparam int unsigned QUOT_W = DIVD_W + 1;
   localparam int unsigned PAD_W  = 11;

   // Width of the divider's iteration counter.
   localparam int unsigned DIV_CNT_W = $clog2(DIVD_W);

   typedef enum logic [1:0] {
      CSR_THRESHOLD   = 2'd0,
      CSR_ORIG_WIDTH  = 2'd1,
      CSR_ORIG_HEIGHT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic              start;
      logic              neg;
      logic [PROD_W-1:0] mag;
      logic [DEN_W-1:0]  den;
   } div_cmd_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quot;
   } div_rsp_type;

endpackage

// File: rtl/core/dhbd_div.sv
// Shared rounding divider: sign * round(mag / den), half away from zero.
// Restoring division, one quotient bit per cycle. Depends on dhbd_pkg.
module dhbd_div import dhbd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   output div_rsp_type rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 neg_ff, neg_in;
   logic [DIVD_W-1:0]    quo_ff, quo_in;
   logic [DVSR_W-1:0]    rem_ff, rem_in;
   logic [DVSR_W-1:0]    dvsr_ff, dvsr_in;
   logic [DVSR_W:0]      trial;
   logic [DVSR_W:0]      diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvsr_in = dvsr_ff;
      trial   = {rem_ff, quo_ff[DIVD_W-1]};
      diff    = trial - {1'b0, dvsr_ff};
      if (cmd.start) begin
         // Rounding is folded in: (2*mag + den) / (2*den).
         busy_in = 1'b1;
         cnt_in  = '0;
         neg_in  = cmd.neg;
         quo_in  = DIVD_W'({cmd.mag, 1'b0}) + DIVD_W'(cmd.den);
         dvsr_in = {cmd.den, 1'b0};
         rem_in  = '0;
      end else if (busy_ff) begin
         if (!diff[DVSR_W]) begin
            rem_in = diff[DVSR_W-1:0];
         end else begin
            rem_in = trial[DVSR_W-1:0];
         end
         quo_in = {quo_ff[DIVD_W-2:0], ~diff[DVSR_W]};
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvsr_ff <= dvsr_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = neg_ff ? (QUOT_W'(0) - {1'b0, quo_ff}) : {1'b0, quo_ff};

endmodule

// File: rtl/core/detection_head_box_decode_top.sv
// Detection head box decoder: a score item is taken every cycle while no box is being built.
// A last-score transfer that beats the threshold stalls the input while its box is built:
// six multiply/divide passes through the shared divider, then two clamp steps,
// the second held while an earlier result still waits. The box is valid in the cycle after that step.
// Synchronous active-high reset restores the register defaults and the running maximum.
// Depends on dhbd_pkg and dhbd_div.
module detection_head_box_decode_top import dhbd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [SCORE_W-1:0]  req_class_score,
   input  logic                req_last_score,
   input  logic signed [15:0]  req_center_x,
   input  logic signed [15:0]  req_center_y,
   input  logic signed [15:0]  req_box_w,
   input  logic signed [15:0]  req_box_h,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [DIM_W-1:0]    rsp_out_x,
   output logic [DIM_W-1:0]    rsp_out_y,
   output logic [DIM_W-1:0]    rsp_out_w,
   output logic [DIM_W-1:0]    rsp_out_h,
   output logic [CLASS_W-1:0]  rsp_class_id,
   output logic [SCORE_W-1:0]  rsp_best_score,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_data
);

   typedef enum logic [2:0] {
      S_IDLE, S_MUL, S_GO, S_WAIT, S_CLAMP_XY, S_CLAMP_WH
   } state_type;

   typedef enum logic [2:0] {
      OP_PADX, OP_PADY, OP_X, OP_Y, OP_W, OP_H
   } op_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   logic [SCORE_W-1:0] thresh_ff, thresh_in;
   logic [DIM_W-1:0]   ow_ff, ow_in;
   logic [DIM_W-1:0]   oh_ff, oh_in;

   logic [SCORE_W-1:0] max_ff, max_in;
   logic [CLASS_W-1:0] class_ff, class_in;
   logic [CLASS_W-1:0] cnt_ff, cnt_in;
   logic               excess_ff, excess_in;

   logic [SCORE_W-1:0] best_ff, best_in;
   logic [CLASS_W-1:0] cls_ff, cls_in;
   logic signed [12:0] left_ff, left_in;
   logic signed [12:0] top_ff, top_in;
   logic signed [11:0] wi_ff, wi_in;
   logic signed [11:0] hi_ff, hi_in;
   logic [DIM_W-1:0]   m_ff, m_in;
   logic [PAD_W-1:0]   padx_ff, padx_in;
   logic [PAD_W-1:0]   pady_ff, pady_in;
   logic signed [QUOT_W-1:0] x_ff, x_in, y_ff, y_in, w_ff, w_in, h_ff, h_in;
   logic [DIM_W-1:0]   xc_ff, xc_in, yc_ff, yc_in;

   logic [PROD_W-1:0]  mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic [DEN_W-1:0]   den_ff, den_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [DIM_W-1:0]   out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic [DIM_W-1:0]   out_w_ff, out_w_in, out_h_ff, out_h_in;
   logic [CLASS_W-1:0] out_cls_ff, out_cls_in;
   logic [SCORE_W-1:0] out_score_ff, out_score_in;

   div_cmd_type div_cmd;
   div_rsp_type div_rsp;

   logic               req_fire;
   logic               take;
   logic [SCORE_W-1:0] new_max;
   logic [CLASS_W-1:0] new_class;
   logic signed [17:0] lx_raw, ly_raw, lx_adj, ly_adj;
   logic signed [15:0] bw_adj, bh_adj;
   logic [DIM_W-1:0]   m_sel;
   logic signed [13:0] dx, dy;
   logic [OPND_W-1:0]  mul_a, mul_b;
   logic signed [QUOT_W-1:0] ow_s, oh_s, wlim_s, hlim_s;
   logic [DIM_W-1:0]   wlim, hlim;

   dhbd_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

   assign req_fire = req_valid && !req_stall;

   // Corner form, truncated toward zero, straight from the input payload.
   always_comb begin
      lx_raw = $signed({req_center_x[15], req_center_x, 1'b0})
             - $signed({{2{req_box_w[15]}}, req_box_w});
      ly_raw = $signed({req_center_y[15], req_center_y, 1'b0})
             - $signed({{2{req_box_h[15]}}, req_box_h});
      lx_adj = lx_raw[17] ? lx_raw + 18'sd31 : lx_raw;
      ly_adj = ly_raw[17] ? ly_raw + 18'sd31 : ly_raw;
      bw_adj = req_box_w[15] ? req_box_w + 16'sd15 : req_box_w;
      bh_adj = req_box_h[15] ? req_box_h + 16'sd15 : req_box_h;
      m_sel  = (ow_ff > oh_ff) ? ow_ff : oh_ff;
      if (m_sel == '0) begin
         m_sel = DIM_W'(1);
      end
   end

   always_comb begin
      take      = !excess_ff && ((cnt_ff == '0) || (req_class_score > max_ff));
      new_max   = take ? req_class_score : max_ff;
      new_class = take ? cnt_ff : class_ff;
   end

   // Operand selection for the shared multiplier ahead of each division.
   always_comb begin
      dx     = $signed({left_ff[12], left_ff}) - $signed({3'b000, padx_ff});
      dy     = $signed({top_ff[12], top_ff}) - $signed({3'b000, pady_ff});
      mul_a  = '0;
      mul_b  = m_ff;
      neg_in = neg_ff;
      den_in = den_ff;
      case (op_ff)
         OP_PADX: begin
            mul_a  = m_ff - ow_ff;
            mul_b  = OPND_W'(NET_INPUT_SIZE);
            neg_in = 1'b0;
            den_in = {m_ff, 1'b0};
         end
         OP_PADY: begin
            mul_a  = m_ff - oh_ff;
            mul_b  = OPND_W'(NET_INPUT_SIZE);
            neg_in = 1'b0;
            den_in = {m_ff, 1'b0};
         end
         OP_X: begin
            mul_a  = dx[13] ? OPND_W'(14'sd0 - dx) : OPND_W'(dx);
            neg_in = dx[13];
            den_in = DEN_W'(NET_INPUT_SIZE);
         end
         OP_Y: begin
            mul_a  = dy[13] ? OPND_W'(14'sd0 - dy) : OPND_W'(dy);
            neg_in = dy[13];
            den_in = DEN_W'(NET_INPUT_SIZE);
         end
         OP_W: begin
            mul_a  = {1'b0, (wi_ff[11] ? 12'd0 - wi_ff : wi_ff)};
            neg_in = wi_ff[11];
            den_in = DEN_W'(NET_INPUT_SIZE);
         end
         OP_H: begin
            mul_a  = {1'b0, (hi_ff[11] ? 12'd0 - hi_ff : hi_ff)};
            neg_in = hi_ff[11];
            den_in = DEN_W'(NET_INPUT_SIZE);
         end
         default: begin
            mul_a = '0;
         end
      endcase
      mag_in = (state_ff == S_MUL) ? PROD_W'(mul_a) * PROD_W'(mul_b) : mag_ff;
      if (state_ff != S_MUL) begin
         neg_in = neg_ff;
         den_in = den_ff;
      end
   end

   assign div_cmd.start = (state_ff == S_GO);
   assign div_cmd.neg   = neg_ff;
   assign div_cmd.mag   = mag_ff;
   assign div_cmd.den   = den_ff;

   always_comb begin
      ow_s   = $signed({{(QUOT_W-DIM_W){1'b0}}, ow_ff});
      oh_s   = $signed({{(QUOT_W-DIM_W){1'b0}}, oh_ff});
      wlim   = ow_ff - xc_ff;
      hlim   = oh_ff - yc_ff;
      wlim_s = $signed({{(QUOT_W-DIM_W){1'b0}}, wlim});
      hlim_s = $signed({{(QUOT_W-DIM_W){1'b0}}, hlim});
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      thresh_in    = thresh_ff;
      ow_in        = ow_ff;
      oh_in        = oh_ff;
      max_in       = max_ff;
      class_in     = class_ff;
      cnt_in       = cnt_ff;
      excess_in    = excess_ff;
      best_in      = best_ff;
      cls_in       = cls_ff;
      left_in      = left_ff;
      top_in       = top_ff;
      wi_in        = wi_ff;
      hi_in        = hi_ff;
      m_in         = m_ff;
      padx_in      = padx_ff;
      pady_in      = pady_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      xc_in        = xc_ff;
      yc_in        = yc_ff;
      rsp_valid_in = rsp_valid_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_w_in     = out_w_ff;
      out_h_in     = out_h_ff;
      out_cls_in   = out_cls_ff;
      out_score_in = out_score_ff;

      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_THRESHOLD:   thresh_in = csr_data;
            CSR_ORIG_WIDTH:  ow_in     = csr_data[DIM_W-1:0];
            CSR_ORIG_HEIGHT: oh_in     = csr_data[DIM_W-1:0];
            default: begin
            end
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (req_fire) begin
         if (!excess_ff) begin
            max_in   = new_max;
            class_in = new_class;
            if ({1'b0, cnt_ff} + 9'd1 >= 9'(MAX_CLASSES)) begin
               excess_in = 1'b1;
            end else begin
               cnt_in = cnt_ff + CLASS_W'(1);
            end
         end
         if (req_last_score) begin
            // Every detection ends here, whether or not a box is built.
            max_in    = '0;
            class_in  = '0;
            cnt_in    = '0;
            excess_in = 1'b0;
            if (new_max > thresh_ff) begin
               best_in  = new_max;
               cls_in   = new_class;
               left_in  = lx_adj[17:5];
               top_in   = ly_adj[17:5];
               wi_in    = bw_adj[15:4];
               hi_in    = bh_adj[15:4];
               m_in     = m_sel;
               op_in    = OP_PADX;
               state_in = S_MUL;
            end
         end
      end

      unique case (state_ff)
         S_IDLE: begin
         end
         S_MUL: begin
            state_in = S_GO;
         end
         S_GO: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (div_rsp.done) begin
               case (op_ff)
                  OP_PADX: padx_in = div_rsp.quot[PAD_W-1:0];
                  OP_PADY: pady_in = div_rsp.quot[PAD_W-1:0];
                  OP_X:    x_in    = $signed(div_rsp.quot);
                  OP_Y:    y_in    = $signed(div_rsp.quot);
                  OP_W:    w_in    = $signed(div_rsp.quot);
                  OP_H:    h_in    = $signed(div_rsp.quot);
                  default: begin
                  end
               endcase
               if (op_ff == OP_H) begin
                  state_in = S_CLAMP_XY;
               end else begin
                  op_in    = op_type'(op_ff + 3'd1);
                  state_in = S_MUL;
               end
            end
         end
         S_CLAMP_XY: begin
            if (x_ff > ow_s) begin
               xc_in = ow_ff;
            end else if (x_ff[QUOT_W-1]) begin
               xc_in = '0;
            end else begin
               xc_in = x_ff[DIM_W-1:0];
            end
            if (y_ff > oh_s) begin
               yc_in = oh_ff;
            end else if (y_ff[QUOT_W-1]) begin
               yc_in = '0;
            end else begin
               yc_in = y_ff[DIM_W-1:0];
            end
            state_in = S_CLAMP_WH;
         end
         S_CLAMP_WH: begin
            // Hold here until the output register is free or being emptied.
            if (!rsp_valid_ff || !rsp_stall) begin
               out_x_in = xc_ff;
               out_y_in = yc_ff;
               if (w_ff > wlim_s) begin
                  out_w_in = wlim;
               end else if (w_ff[QUOT_W-1]) begin
                  out_w_in = '0;
               end else begin
                  out_w_in = w_ff[DIM_W-1:0];
               end
               if (h_ff > hlim_s) begin
                  out_h_in = hlim;
               end else if (h_ff[QUOT_W-1]) begin
                  out_h_in = '0;
               end else begin
                  out_h_in = h_ff[DIM_W-1:0];
               end
               out_cls_in   = cls_ff;
               out_score_in = best_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_PADX;
         rsp_valid_ff <= 1'b0;
         thresh_ff    <= SCORE_W'(16384);
         ow_ff        <= DIM_W'(640);
         oh_ff        <= DIM_W'(480);
         max_ff       <= '0;
         class_ff     <= '0;
         cnt_ff       <= '0;
         excess_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
         thresh_ff    <= thresh_in;
         ow_ff        <= ow_in;
         oh_ff        <= oh_in;
         max_ff       <= max_in;
         class_ff     <= class_in;
         cnt_ff       <= cnt_in;
         excess_ff    <= excess_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff      <= best_in;
      cls_ff       <= cls_in;
      left_ff      <= left_in;
      top_ff       <= top_in;
      wi_ff        <= wi_in;
      hi_ff        <= hi_in;
      m_ff         <= m_in;
      padx_ff      <= padx_in;
      pady_ff      <= pady_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      w_ff         <= w_in;
      h_ff         <= h_in;
      xc_ff        <= xc_in;
      yc_ff        <= yc_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      den_ff       <= den_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_w_ff     <= out_w_in;
      out_h_ff     <= out_h_in;
      out_cls_ff   <= out_cls_in;
      out_score_ff <= out_score_in;
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_x      = out_x_ff;
   assign rsp_out_y      = out_y_ff;
   assign rsp_out_w      = out_w_ff;
   assign rsp_out_h      = out_h_ff;
   assign rsp_class_id   = out_cls_ff;
   assign rsp_best_score = out_score_ff;

   // The class counter parks on the last class index once further scores are ignored.
   a_excess_count: assert property (@(posedge clock) disable iff (reset)
      excess_ff |-> cnt_ff == CLASS_W'(MAX_CLASSES - 1))
      else $error("class counter not parked while scores are ignored");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == S_WAIT)
      else $error("divider finished outside the wait state");

   a_new_result_score: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> rsp_best_score > thresh_ff)
      else $error("result emitted at or below the confidence threshold");

   a_box_in_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_x <= ow_ff && rsp_out_w <= ow_ff - rsp_out_x)
      else $error("result box leaves the frame horizontally");

endmodule
